@@ sv/geiger_window_dose_rate_unit_assert.svh @@
// ----------------------------------------------------------------------------
// geiger window dose rate unit assertion macros
// shared concurrent assertion forms, clocked on clk and reset by rst_n
// ----------------------------------------------------------------------------
`ifndef GEIGER_WINDOW_DOSE_RATE_UNIT_ASSERT_SVH
`define GEIGER_WINDOW_DOSE_RATE_UNIT_ASSERT_SVH

// same-cycle implication
`define GWD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gwd assertion failed");

// next-cycle implication
`define GWD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gwd assertion failed");

`endif

@@ sv/gwd_pkg.sv @@
// ----------------------------------------------------------------------------
// gwd_pkg
// shared types and constants of the geiger window dose rate unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gwd_pkg;

    localparam int BIN_COUNT = 200;
    localparam int PTR_W     = $clog2(BIN_COUNT);

    localparam logic [15:0] MS_PER_MIN       = 16'd60000;
    localparam logic [15:0] BIN_INTERVAL_RST = 16'd6000;
    localparam logic [15:0] ALPHA_RST        = 16'd13576;

    // register index, taken from paddr[2]
    localparam logic REG_BIN_INTERVAL = 1'b0;
    localparam logic REG_ALPHA        = 1'b1;

    localparam int DIV_NUM_W = 72;
    localparam int DIV_DEN_W = 48;

    typedef struct packed {
        logic [15:0] pulse_count;
        logic [15:0] noise_count;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [31:0] window_count;
        logic [31:0] integration_ms;
        logic [31:0] cpm_x256;
        logic [31:0] dose_rate_q16;
        logic [31:0] dose_error_q16;
        logic        noise_seen;
        logic        radiation_seen;
    } out_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

@@ sv/gwd_ram.sv @@
// ----------------------------------------------------------------------------
// gwd_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gwd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 200
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ sv/gwd_div.sv @@
// ----------------------------------------------------------------------------
// gwd_div
// restoring divider, one quotient bit per cycle, quotient saturates at 32 bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gwd_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [gwd_pkg::DIV_NUM_W-1:0]   num,
    input  wire logic [gwd_pkg::DIV_DEN_W-1:0]   den,
    output gwd_pkg::unit_stat_t                  stat,
    output logic      [31:0]                     quo
);

    logic [gwd_pkg::DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [gwd_pkg::DIV_DEN_W-1:0] den_reg;
    logic [31:0]                   lo_reg, lo_next;
    logic [31:0]                   q_reg, q_next;
    logic [5:0]                    cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [gwd_pkg::DIV_DEN_W:0]   trial;
    logic [gwd_pkg::DIV_NUM_W-33:0] num_hi;
    logic                          over;

    assign num_hi = num[gwd_pkg::DIV_NUM_W-1:32];
    // quotient exceeds 32 bits exactly when the upper part already reaches den
    assign over   = {{(gwd_pkg::DIV_DEN_W-(gwd_pkg::DIV_NUM_W-32)){1'b0}}, num_hi} >= den;
    assign trial  = {rem_reg, lo_reg[31]};

    always_comb
    begin
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            lo_next  = num[31:0];
            cnt_next = 6'd32;
            if (over)
            begin
                q_next    = '1;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = {{(gwd_pkg::DIV_DEN_W-(gwd_pkg::DIV_NUM_W-32)){1'b0}}, num_hi};
                q_next    = '0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = gwd_pkg::DIV_DEN_W'(trial - {1'b0, den_reg});
                q_next   = {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[gwd_pkg::DIV_DEN_W-1:0];
                q_next   = {q_reg[30:0], 1'b0};
            end
            lo_next  = {lo_reg[30:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = q_reg;

endmodule

`default_nettype wire

@@ sv/gwd_sqrt.sv @@
// ----------------------------------------------------------------------------
// gwd_sqrt
// integer square root of val * 2^32, one root bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gwd_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] val,
    output gwd_pkg::unit_stat_t stat,
    output logic      [31:0] root
);

    logic [33:0] rem_reg, rem_next;
    logic [31:0] xs_reg, xs_next;
    logic [31:0] root_reg, root_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [35:0] part;
    logic [35:0] trial;

    // two radicand bits enter per step, zeros once val is used up
    assign part  = {rem_reg, xs_reg[31:30]};
    assign trial = {2'b00, root_reg, 2'b01};

    always_comb
    begin
        rem_next  = rem_reg;
        xs_next   = xs_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            xs_next   = val;
            root_next = '0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (part >= trial)
            begin
                rem_next  = 34'(part - trial);
                root_next = {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = part[33:0];
                root_next = {root_reg[30:0], 1'b0};
            end
            xs_next  = {xs_reg[29:0], 2'b00};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        xs_reg   <= xs_next;
        root_reg <= root_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

`default_nettype wire

@@ sv/geiger_window_dose_rate_unit.sv @@
// ----------------------------------------------------------------------------
// geiger window dose rate unit
// sliding window pulse counter with cpm, dose rate and dose error outputs
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  in        input      in_valid / in_ready   in_data  (gwd_pkg::in_item_t)
//  out       output     out_valid / out_ready out_data (gwd_pkg::out_item_t)
//  apb       input      psel/penable/pwrite   paddr, pwdata, prdata
//
// one item at a time, paced by three serial divisions in the shared divider, each a
// start, 32 steps and done, and by an extra S_SUB state when the ring advances; a
// saturating division skips the steps; the root runs beside the first
// a finished result waits in the output register while the next beat is taken
// bin store is 200 words of ram; per-bin valid flops clear at reset, no sweep
// reset is asynchronous, active low
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "geiger_window_dose_rate_unit_assert.svh"

module geiger_window_dose_rate_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire gwd_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output gwd_pkg::out_item_t      out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ADD     = 4'd1;
    localparam logic [3:0] S_SUB     = 4'd2;
    localparam logic [3:0] S_MUL     = 4'd3;
    localparam logic [3:0] S_ITIME   = 4'd4;
    localparam logic [3:0] S_DEN     = 4'd5;
    localparam logic [3:0] S_CPM_GO  = 4'd6;
    localparam logic [3:0] S_CPM_W   = 4'd7;
    localparam logic [3:0] S_DOSE_GO = 4'd8;
    localparam logic [3:0] S_DOSE_W  = 4'd9;
    localparam logic [3:0] S_SMUL    = 4'd10;
    localparam logic [3:0] S_ERR_GO  = 4'd11;
    localparam logic [3:0] S_ERR_W   = 4'd12;
    localparam logic [3:0] S_OUT     = 4'd13;

    localparam int PW = gwd_pkg::PTR_W;
    localparam int BIN_VLD_HI = gwd_pkg::BIN_COUNT - 1;

    logic [3:0]  state_reg, state_next;
    logic [15:0] interval_reg;
    logic [15:0] alpha_reg;
    logic [PW-1:0] ptr_reg, ptr_next, ptr_inc;
    logic [PW-1:0] filled_reg, filled_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] bin_start_reg, bin_start_next;
    gwd_pkg::in_item_t item_reg;
    logic        adv;
    logic [31:0] bin_cur;
    logic [31:0] add_val;

    logic [BIN_VLD_HI:0] vld_reg;
    logic        rd_vld_reg;

    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [PW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic [31:0] fi_reg;
    logic [47:0] tm_reg;
    logic [31:0] itime_reg;
    logic [47:0] den_reg;
    logic [47:0] s60_reg;
    logic [31:0] cpm_reg;
    logic [31:0] dose_reg;

    logic                               div_start;
    logic [gwd_pkg::DIV_NUM_W-1:0]      div_num;
    gwd_pkg::unit_stat_t                div_stat;
    logic [31:0]                        div_quo;
    logic                               sq_start;
    gwd_pkg::unit_stat_t                sq_stat;
    logic [31:0]                        sq_root;

    gwd_pkg::out_item_t out_reg;
    logic               out_valid_reg;
    logic               cfg_we;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= gwd_pkg::BIN_INTERVAL_RST;
            alpha_reg    <= gwd_pkg::ALPHA_RST;
        end
        else if (cfg_we)
        begin
            unique case (paddr[2])
                gwd_pkg::REG_BIN_INTERVAL: interval_reg <= pwdata[15:0];
                gwd_pkg::REG_ALPHA:        alpha_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            gwd_pkg::REG_BIN_INTERVAL: prdata = {16'd0, interval_reg};
            gwd_pkg::REG_ALPHA:        prdata = {16'd0, alpha_reg};
            default:                   prdata = '0;
        endcase
    end

    // bin store
    gwd_ram #(
        .WIDTH (32),
        .DEPTH (gwd_pkg::BIN_COUNT)
    ) u_bins (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign ptr_inc = (ptr_reg == PW'(gwd_pkg::BIN_COUNT - 1)) ? '0 : ptr_reg + 1'b1;
    assign bin_cur = rd_vld_reg ? ram_rdata : 32'd0;
    assign add_val = (item_reg.noise_count == 16'd0) ? {16'd0, item_reg.pulse_count} : 32'd0;
    assign adv     = (item_reg.now_ms - bin_start_reg) >= {16'd0, interval_reg};

    always_comb
    begin
        ram_raddr = ptr_reg;
        ram_we    = 1'b0;
        ram_waddr = ptr_reg;
        ram_wdata = '0;
        if (state_reg == S_ADD)
        begin
            ram_raddr = ptr_inc;
            ram_we    = 1'b1;
            ram_wdata = bin_cur + add_val;
        end
        else if (state_reg == S_SUB)
        begin
            ram_we = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= vld_reg[ram_raddr];
            if (ram_we)
            begin
                vld_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    // sequencer
    assign div_start = (state_reg == S_CPM_GO) || (state_reg == S_DOSE_GO)
                    || (state_reg == S_ERR_GO);
    assign sq_start  = (state_reg == S_CPM_GO);

    always_comb
    begin
        unique case (state_reg)
            S_CPM_GO:  div_num = {16'd0, tm_reg, 8'd0};
            S_DOSE_GO: div_num = {tm_reg, 24'd0};
            default:   div_num = {16'd0, s60_reg, 8'd0};
        endcase
    end

    gwd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   ((state_reg == S_CPM_GO) ? {16'd0, itime_reg} : den_reg),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    gwd_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .val   (total_reg),
        .stat  (sq_stat),
        .root  (sq_root)
    );

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        filled_next    = filled_reg;
        total_next     = total_reg;
        bin_start_next = bin_start_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                total_next = total_reg + add_val;
                if (adv)
                begin
                    bin_start_next = bin_start_reg + {16'd0, interval_reg};
                    ptr_next       = ptr_inc;
                    if (filled_reg != PW'(gwd_pkg::BIN_COUNT - 1))
                    begin
                        filled_next = filled_reg + 1'b1;
                    end
                    state_next = S_SUB;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_SUB:
            begin
                total_next = total_reg - bin_cur;
                state_next = S_MUL;
            end
            S_MUL:    state_next = S_ITIME;
            S_ITIME:  state_next = S_DEN;
            S_DEN:    state_next = S_CPM_GO;
            S_CPM_GO: state_next = S_CPM_W;
            S_CPM_W:
            begin
                if (div_stat.done)
                begin
                    state_next = S_DOSE_GO;
                end
            end
            S_DOSE_GO: state_next = S_DOSE_W;
            S_DOSE_W:
            begin
                if (div_stat.done)
                begin
                    state_next = S_SMUL;
                end
            end
            S_SMUL:
            begin
                if (!sq_stat.busy)
                begin
                    state_next = S_ERR_GO;
                end
            end
            S_ERR_GO: state_next = S_ERR_W;
            S_ERR_W:
            begin
                if (div_stat.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            filled_reg    <= '0;
            total_reg     <= '0;
            bin_start_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            filled_reg    <= filled_next;
            total_reg     <= total_next;
            bin_start_reg <= bin_start_next;
        end
    end

    // datapath registers, one multiply between registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
        if (state_reg == S_MUL)
        begin
            fi_reg <= 32'(filled_reg) * 32'(interval_reg);
            tm_reg <= 48'(total_reg) * 48'(gwd_pkg::MS_PER_MIN);
        end
        if (state_reg == S_ITIME)
        begin
            itime_reg <= fi_reg + item_reg.now_ms - bin_start_reg;
        end
        if (state_reg == S_DEN)
        begin
            den_reg <= 48'(itime_reg) * 48'(alpha_reg);
        end
        if (state_reg == S_CPM_W && div_stat.done)
        begin
            cpm_reg <= div_quo;
        end
        if (state_reg == S_DOSE_W && div_stat.done)
        begin
            dose_reg <= div_quo;
        end
        if (state_reg == S_SMUL)
        begin
            s60_reg <= 48'(sq_root) * 48'(gwd_pkg::MS_PER_MIN);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_OUT && (!out_valid_reg || out_ready))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && (!out_valid_reg || out_ready))
        begin
            out_reg.window_count   <= total_reg;
            out_reg.integration_ms <= itime_reg;
            out_reg.noise_seen     <= item_reg.noise_count != 16'd0;
            out_reg.radiation_seen <= item_reg.pulse_count != 16'd0;
            if (itime_reg == 32'd0)
            begin
                out_reg.cpm_x256       <= '0;
                out_reg.dose_rate_q16  <= '0;
                out_reg.dose_error_q16 <= '0;
            end
            else if (alpha_reg == 16'd0)
            begin
                out_reg.cpm_x256       <= cpm_reg;
                out_reg.dose_rate_q16  <= '1;
                out_reg.dose_error_q16 <= '1;
            end
            else
            begin
                out_reg.cpm_x256       <= cpm_reg;
                out_reg.dose_rate_q16  <= dose_reg;
                out_reg.dose_error_q16 <= div_quo;
            end
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `GWD_ASSERT_NOW(a_ptr_range, 1'b1, ptr_reg <= PW'(gwd_pkg::BIN_COUNT - 1))
    `GWD_ASSERT_NOW(a_filled_range, 1'b1, filled_reg <= PW'(gwd_pkg::BIN_COUNT - 1))
    `GWD_ASSERT_NOW(a_root_ready, state_reg == S_ERR_GO, !sq_stat.busy)
    `GWD_ASSERT_NEXT(a_div_runs, div_start, div_stat.busy || div_stat.done)

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// geiger window dose rate unit testbench
// drives period beats over valid/ready, writes the bin interval and alpha
// registers between phases, and checks every result beat against a local model
// of the sliding window, the divider and the square root, or a written expectation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 400;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    gwd_pkg::in_item_t  in_data;
    logic        out_valid;
    logic        out_ready;
    gwd_pkg::out_item_t out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    geiger_window_dose_rate_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // window state mirrored on the bench side
    logic [31:0] bins_m [gwd_pkg::BIN_COUNT];
    int          ptr_m;
    int          filled_m;
    logic [31:0] total_m;
    logic [31:0] last_m;
    logic [31:0] start_m;
    logic [15:0] interval_m;
    logic [15:0] alpha_m;

    gwd_pkg::out_item_t pending_results[$];
    int          errors;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // restoring division of a 128-bit numerator, quotient saturated to 32 bits
    function automatic logic [31:0] sat_quotient(logic [127:0] num, logic [63:0] den);
        logic [64:0] rem;
        logic [31:0] q;
        logic        over;
        rem  = '0;
        q    = '0;
        over = 1'b0;
        for (int i = 127; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem = rem - {1'b0, den};
                if (i >= 32)
                    over = 1'b1;
                else
                    q[i] = 1'b1;
            end
        end
        return over ? 32'hFFFF_FFFF : q;
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] one;
        rem = x;
        res = '0;
        one = 64'd1 << 62;
        while (one > rem)
            one = one >> 2;
        while (one != 0)
        begin
            if (rem >= res + one)
            begin
                rem = rem - (res + one);
                res = (res >> 1) + one;
            end
            else
                res = res >> 1;
            one = one >> 2;
        end
        return res;
    endfunction

    function automatic void window_reset();
        foreach (bins_m[i])
            bins_m[i] = '0;
        ptr_m      = 0;
        filled_m   = 0;
        total_m    = '0;
        last_m     = '0;
        start_m    = '0;
        interval_m = gwd_pkg::BIN_INTERVAL_RST;
        alpha_m    = gwd_pkg::ALPHA_RST;
    endfunction

    function automatic gwd_pkg::out_item_t window_advance(gwd_pkg::in_item_t it);
        gwd_pkg::out_item_t r;
        logic [31:0] itime;
        logic [63:0] tm;
        logic [63:0] den;
        logic [63:0] s;
        if (it.noise_count == 0)
        begin
            bins_m[ptr_m] += 32'(it.pulse_count);
            total_m       += 32'(it.pulse_count);
        end
        if (32'(it.now_ms - start_m) >= 32'(interval_m))
        begin
            start_m += 32'(interval_m);
            ptr_m    = (ptr_m + 1) % gwd_pkg::BIN_COUNT;
            if (filled_m < gwd_pkg::BIN_COUNT - 1)
                filled_m++;
            total_m      -= bins_m[ptr_m];
            bins_m[ptr_m] = '0;
        end
        last_m = it.now_ms;
        itime  = 32'(filled_m) * 32'(interval_m) + last_m - start_m;
        r = '0;
        r.window_count   = total_m;
        r.integration_ms = itime;
        if (itime != 0)
        begin
            tm         = 64'(total_m) * 64'd60000;
            r.cpm_x256 = sat_quotient({64'd0, tm << 8}, 64'(itime));
            if (alpha_m == 0)
            begin
                r.dose_rate_q16  = 32'hFFFF_FFFF;
                r.dose_error_q16 = 32'hFFFF_FFFF;
            end
            else
            begin
                den = 64'(itime) * 64'(alpha_m);
                s   = root_floor(64'(total_m) << 32);
                r.dose_rate_q16  = sat_quotient({tm >> 40, tm << 24}, den);
                r.dose_error_q16 = sat_quotient({64'd0, s * (64'd60000 << 8)}, den);
            end
        end
        r.noise_seen     = it.noise_count != 0;
        r.radiation_seen = it.pulse_count != 0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result side: random stall, compare each beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected beat", out_data.window_count, '0);
                else
                begin
                    gwd_pkg::out_item_t w;
                    w = pending_results.pop_front();
                    if (out_data.window_count !== w.window_count)
                        report_mismatch("window_count", out_data.window_count,
                                        w.window_count);
                    if (out_data.integration_ms !== w.integration_ms)
                        report_mismatch("integration_ms", out_data.integration_ms,
                                        w.integration_ms);
                    if (out_data.cpm_x256 !== w.cpm_x256)
                        report_mismatch("cpm_x256", out_data.cpm_x256, w.cpm_x256);
                    if (out_data.dose_rate_q16 !== w.dose_rate_q16)
                        report_mismatch("dose_rate_q16", out_data.dose_rate_q16,
                                        w.dose_rate_q16);
                    if (out_data.dose_error_q16 !== w.dose_error_q16)
                        report_mismatch("dose_error_q16", out_data.dose_error_q16,
                                        w.dose_error_q16);
                    if (out_data.noise_seen !== w.noise_seen)
                        report_mismatch("noise_seen", 32'(out_data.noise_seen),
                                        32'(w.noise_seen));
                    if (out_data.radiation_seen !== w.radiation_seen)
                        report_mismatch("radiation_seen", 32'(out_data.radiation_seen),
                                        32'(w.radiation_seen));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == gwd_pkg::REG_BIN_INTERVAL)
            interval_m = value[15:0];
        else
            alpha_m = value[15:0];
        @(posedge clk);
    endtask

    // send one period beat; the expectation is queued at acceptance
    task automatic send_period(gwd_pkg::in_item_t it, bit typed, gwd_pkg::out_item_t want);
        gwd_pkg::out_item_t p;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        p = window_advance(it);
        pending_results.push_back(typed ? want : p);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);
    endtask

    typedef struct {
        gwd_pkg::in_item_t  it;
        bit                 typed;
        gwd_pkg::out_item_t want;
    } period_row_t;

    period_row_t directed_rows[$];
    logic [31:0] clock_ms;

    function automatic period_row_t row(logic [15:0] p, logic [15:0] n, logic [31:0] t);
        period_row_t r;
        r.it    = '{pulse_count: p, noise_count: n, now_ms: t};
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    task automatic random_phase(int count, int max_step, int noise_pct);
        gwd_pkg::in_item_t it;
        for (int k = 0; k < count; k++)
        begin
            clock_ms += $urandom_range(max_step);
            it.now_ms      = ($urandom_range(99) < 3) ? $urandom() : clock_ms;
            it.pulse_count = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom());
            it.noise_count = ($urandom_range(99) < noise_pct) ? 16'($urandom()) : 16'd0;
            send_period(it, 1'b0, '0);
        end
    endtask

    initial
    begin
        period_row_t r;
        errors        = 0;
        idle_cycles   = 0;
        send_idle_pct = 19;
        recv_idle_pct = 72;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        window_reset();
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // at time zero nothing has integrated: outputs are all zero
        r = row(16'd0, 16'd0, 32'd0);
        r.typed = 1'b1;
        directed_rows.push_back(r);
        // noise discards pulses, both flags set
        r = row(16'hFFFF, 16'hFFFF, 32'd0);
        r.typed = 1'b1;
        r.want.noise_seen     = 1'b1;
        r.want.radiation_seen = 1'b1;
        directed_rows.push_back(r);
        directed_rows.push_back(row(16'hFFFF, 16'd0, 32'd1));
        directed_rows.push_back(row(16'd1, 16'd1, 32'd5999));
        directed_rows.push_back(row(16'd100, 16'd0, 32'd6000));
        // several intervals passed at once, still one advance
        directed_rows.push_back(row(16'd7, 16'd0, 32'd40000));
        directed_rows.push_back(row(16'hAAAA, 16'd0, 32'd41000));
        directed_rows.push_back(row(16'h5555, 16'd0, 32'hFFFF_FFFF));
        directed_rows.push_back(row(16'd3, 16'h8000, 32'h8000_0000));
        foreach (directed_rows[i])
            send_period(directed_rows[i].it, directed_rows[i].typed,
                        directed_rows[i].want);
        drain();

        // extremes of the registers, including zero interval and zero alpha
        reg_write(3'd0, 32'd0);
        reg_write(3'd4, 32'd0);
        for (int i = 0; i < 6; i++)
        begin
            r = row(16'($urandom()), 16'd0, 32'(i * 10));
            send_period(r.it, 1'b0, '0);
        end
        drain();
        reg_write(3'd0, 32'd1);
        reg_write(3'd4, 32'd65535);
        for (int i = 0; i < 6; i++)
        begin
            r = row(16'hFFFF, 16'd0, 32'(i));
            send_period(r.it, 1'b0, '0);
        end
        drain();
        reg_write(3'd0, 32'd65535);
        reg_write(3'd4, 32'd1);
        clock_ms = 32'hFFFF_0000;
        random_phase(20, 70000, 10);
        drain();

        // random phases: receiver-heavy idling, sender-heavy, then none
        reg_write(3'd0, 32'd50);
        reg_write(3'd4, 32'd13576);
        random_phase(170, 120, 15);
        drain();
        send_idle_pct = 72;
        recv_idle_pct = 19;
        reg_write(3'd0, 32'($urandom_range(1, 400)));
        reg_write(3'd4, 32'($urandom_range(1, 65535)));
        random_phase(170, 300, 15);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        reg_write(3'd0, 32'd6000);
        reg_write(3'd4, 32'd256);
        clock_ms = $urandom();
        random_phase(160, 9000, 15);
        drain();

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
